// ===== src/scanline_timing_bitmap_renderer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scanline timing renderer
// Shared property forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_TIMING_BITMAP_RENDERER_DEFINES_SVH
`define SCANLINE_TIMING_BITMAP_RENDERER_DEFINES_SVH

// consequent checked in the same cycle
`define STBR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stbr: assertion failed");

// consequent checked in the next cycle
`define STBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stbr: assertion failed");

`endif

// ===== src/stbr_pkg.sv =====
// ----------------------------------------------------------------------------
// stbr_pkg
// Types and fixed constants of the scanline timing and bitmap renderer.
// ----------------------------------------------------------------------------
package stbr_pkg;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_VRAM_WR = 2'd1,
    CMD_PAL_WR  = 2'd2,
    CMD_PIX_RD  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] vram_address;
    logic [7:0]  palette_index;
    logic [15:0] write_data;
    logic [7:0]  pixel_row;
    logic [7:0]  pixel_column;
  } item_t;

  typedef struct packed {
    logic [7:0]  line_number;
    logic [10:0] cycle_in_line;
    logic        vblank_flag;
    logic        hblank_flag;
    logic [15:0] pixel_value;
  } result_t;

  typedef enum logic [1:0] {
    RK_FILL,
    RK_DIRECT,
    RK_INDEX
  } render_kind_e;

  localparam int unsigned REQ_VAW = 16;
  localparam int unsigned REQ_PAW = 8;
  localparam int unsigned REQ_FAW = 20;

  // renderer to memory ports
  typedef struct packed {
    logic               vram_re;
    logic [REQ_VAW-1:0] vram_addr;
    logic               pal_re;
    logic [REQ_PAW-1:0] pal_addr;
    logic               frame_we;
    logic [REQ_FAW-1:0] frame_addr;
    logic [15:0]        frame_wdata;
  } mem_req_t;

  localparam logic [2:0]  MODE_DIRECT      = 3'd3;
  localparam logic [2:0]  MODE_INDEX       = 3'd4;
  localparam int unsigned HBLANK_CYCLE     = 1004;
  localparam int unsigned RENDER_CYCLE     = 960;
  localparam int unsigned FRAME_SEL_OFFSET = 32'hA000;

endpackage

// ===== src/stbr_ram.sv =====
// ----------------------------------------------------------------------------
// stbr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stbr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/stbr_render.sv =====
// ----------------------------------------------------------------------------
// stbr_render
// Line render engine: three-stage video memory / palette / frame pipeline.
// ----------------------------------------------------------------------------
module stbr_render #(
  parameter int unsigned PIXELS_PER_LINE = 240,
  parameter int unsigned VISIBLE_LINES   = 160,
  parameter int unsigned TOTAL_LINES     = 228,
  parameter int unsigned VRAM_WORDS      = 49152
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  stbr_pkg::render_kind_e         kind_i,
  input  logic                           frame_sel_i,
  input  logic [$clog2(TOTAL_LINES)-1:0] line_i,
  input  logic [15:0]                    vram_rdata_i,
  input  logic [15:0]                    pal_rdata_i,
  output stbr_pkg::mem_req_t             req_o,
  output logic                           busy_o
);
  import stbr_pkg::*;

  localparam int unsigned LW  = $clog2(TOTAL_LINES);
  localparam int unsigned FAW = $clog2(PIXELS_PER_LINE * VISIBLE_LINES);
  localparam int unsigned CLW = $clog2(PIXELS_PER_LINE);
  localparam int unsigned BAW = $clog2(FRAME_SEL_OFFSET + PIXELS_PER_LINE * VISIBLE_LINES);

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_ISSUE,
    RS_DRAIN
  } rstate_e;

  rstate_e        state_q;
  logic [CLW-1:0] col_q;
  logic           s1_v_q, s2_v_q;

  render_kind_e   kind_q;
  logic           sel_q;
  logic [FAW-1:0] base_q;
  logic [FAW-1:0] s1_pix_q, s2_pix_q;
  logic           s1_odd_q, s1_ok_q;
  logic [15:0]    s2_half_q;

  logic [FAW+LW-1:0] base_prod;
  logic [FAW:0]      pix_w;
  logic [FAW-1:0]    pix;
  logic [BAW:0]      byte_w;
  logic [BAW:0]      half_idx;
  logic              ok0;
  logic              issuing;
  logic [7:0]        byte_val;

  assign base_prod = (FAW+LW)'(line_i) * (FAW+LW)'(PIXELS_PER_LINE);
  assign issuing   = (state_q == RS_ISSUE);

  // stage 0: video memory address
  always_comb begin
    pix_w    = (FAW+1)'(base_q) + (FAW+1)'(col_q);
    pix      = pix_w[FAW-1:0];
    byte_w   = (sel_q ? (BAW+1)'(FRAME_SEL_OFFSET) : '0) + (BAW+1)'(pix);
    half_idx = (kind_q == RK_DIRECT) ? (BAW+1)'(pix) : (byte_w >> 1);
    ok0      = half_idx < (BAW+1)'(VRAM_WORDS);
  end

  // stage 1: byte pick and palette address
  always_comb begin
    byte_val = s1_ok_q ? (s1_odd_q ? vram_rdata_i[15:8] : vram_rdata_i[7:0]) : 8'd0;
  end

  always_comb begin
    req_o             = '0;
    req_o.vram_re     = issuing && (kind_q != RK_FILL) && ok0;
    req_o.vram_addr   = REQ_VAW'(half_idx);
    req_o.pal_re      = s1_v_q && (kind_q != RK_DIRECT);
    req_o.pal_addr    = (kind_q == RK_FILL) ? '0 : byte_val;
    req_o.frame_we    = s2_v_q;
    req_o.frame_addr  = REQ_FAW'(s2_pix_q);
    req_o.frame_wdata = (kind_q == RK_DIRECT) ? s2_half_q : pal_rdata_i;
  end

  assign busy_o = (state_q != RS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      col_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      s1_v_q <= issuing;
      s2_v_q <= s1_v_q;
      case (state_q)
        RS_IDLE: begin
          if (start_i) begin
            state_q <= RS_ISSUE;
            col_q   <= '0;
          end
        end
        RS_ISSUE: begin
          if (col_q == CLW'(PIXELS_PER_LINE - 1)) begin
            state_q <= RS_DRAIN;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        RS_DRAIN: begin
          if (!s1_v_q) begin
            state_q <= RS_IDLE;
          end
        end
        default: state_q <= RS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == RS_IDLE)) begin
      kind_q <= kind_i;
      sel_q  <= frame_sel_i;
      base_q <= base_prod[FAW-1:0];
    end
    s1_pix_q  <= pix;
    s1_odd_q  <= byte_w[0];
    s1_ok_q   <= ok0;
    s2_pix_q  <= s1_pix_q;
    s2_half_q <= s1_ok_q ? vram_rdata_i : 16'd0;
  end

endmodule

// ===== src/scanline_timing_bitmap_renderer.sv =====
// Results: every command's result strobes in the cycle after its transfer.
// Throughput: one command per cycle while busy is low; a tick at the render cycle of a
// visible line keeps busy high while the pipeline walks it in fill, direct or index mode.
// Reset: counters, flags, display control and the render engine clear at once;
// video memory, palette and frame store are not cleared and hold unknown data.
// ----------------------------------------------------------------------------
// scanline_timing_bitmap_renderer
// Scanline timing with bitmap line rendering into a frame store.
// ----------------------------------------------------------------------------
module scanline_timing_bitmap_renderer #(
  parameter int unsigned PIXELS_PER_LINE = 240,
  parameter int unsigned VISIBLE_LINES   = 160,
  parameter int unsigned CYCLES_PER_LINE = 1232,
  parameter int unsigned TOTAL_LINES     = 228,
  parameter int unsigned VRAM_WORDS      = 49152
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              start,
  input  stbr_pkg::item_t   item_i,
  output logic              busy,
  output logic              result_valid_o,
  output stbr_pkg::result_t result_o
);
  import stbr_pkg::*;

  localparam int unsigned LW  = $clog2(TOTAL_LINES);
  localparam int unsigned CW  = $clog2(CYCLES_PER_LINE);
  localparam int unsigned FAW = $clog2(PIXELS_PER_LINE * VISIBLE_LINES);
  localparam int unsigned VAW = $clog2(VRAM_WORDS);

  logic [15:0]   dctl_q;
  logic [LW-1:0] line_q, line_d;
  logic [CW-1:0] cyc_q, cyc_d;
  logic          vb_q, vb_d, hb_q, hb_d;
  logic          res_v_q, rd_ok_q;

  logic          accept;
  logic          go;
  render_kind_e  go_kind;
  logic [CW:0]   cyc_inc;
  logic [LW:0]   line_inc;
  logic          rd_in_frame;
  logic [FAW:0]  rd_addr_w;
  logic          vram_we;
  logic [31:0]   line_ext, cyc_ext;

  mem_req_t      req;
  logic          rbusy;
  logic [15:0]   vram_rdata, pal_rdata, frame_rdata;

  assign accept = start && !busy;
  assign busy   = rbusy;

  always_comb begin
    line_d   = line_q;
    cyc_d    = cyc_q;
    vb_d     = vb_q;
    hb_d     = hb_q;
    go       = 1'b0;
    go_kind  = RK_FILL;
    cyc_inc  = (CW+1)'(cyc_q) + 1'b1;
    line_inc = (LW+1)'(line_q) + 1'b1;
    if (accept && (item_i.cmd == CMD_TICK)) begin
      if ((LW+1)'(line_q) >= (LW+1)'(VISIBLE_LINES)) begin
        if (cyc_inc == (CW+1)'(CYCLES_PER_LINE)) begin
          cyc_d = '0;
          if (line_inc == (LW+1)'(TOTAL_LINES)) begin
            line_d = '0;
            vb_d   = 1'b0;
            hb_d   = 1'b0;
          end else begin
            line_d = line_inc[LW-1:0];
          end
        end else begin
          cyc_d = cyc_inc[CW-1:0];
        end
      end else if (cyc_inc == (CW+1)'(CYCLES_PER_LINE)) begin
        cyc_d  = '0;
        line_d = line_inc[LW-1:0];
        if (line_inc == (LW+1)'(VISIBLE_LINES)) begin
          vb_d = 1'b1;
          hb_d = 1'b1;
        end else begin
          vb_d = 1'b0;
          hb_d = 1'b0;
        end
      end else begin
        cyc_d = cyc_inc[CW-1:0];
        if (cyc_inc == (CW+1)'(HBLANK_CYCLE)) begin
          hb_d = 1'b1;
        end else if (cyc_inc == (CW+1)'(RENDER_CYCLE)) begin
          if (dctl_q[15:8] == 8'd0) begin
            go      = 1'b1;
            go_kind = RK_FILL;
          end else begin
            case (dctl_q[2:0])
              MODE_DIRECT: begin
                go      = 1'b1;
                go_kind = RK_DIRECT;
              end
              MODE_INDEX: begin
                go      = 1'b1;
                go_kind = RK_INDEX;
              end
              default: go = 1'b0;
            endcase
          end
        end
      end
    end
  end

  assign rd_in_frame = (32'(item_i.pixel_row) < 32'(VISIBLE_LINES)) &&
                       (32'(item_i.pixel_column) < 32'(PIXELS_PER_LINE));
  assign rd_addr_w   = (FAW+1)'(item_i.pixel_row) * (FAW+1)'(PIXELS_PER_LINE) +
                       (FAW+1)'(item_i.pixel_column);
  assign vram_we     = accept && (item_i.cmd == CMD_VRAM_WR) &&
                       (32'(item_i.vram_address) < 32'(VRAM_WORDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dctl_q  <= '0;
      line_q  <= '0;
      cyc_q   <= '0;
      vb_q    <= 1'b0;
      hb_q    <= 1'b0;
      res_v_q <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dctl_q <= cfg_wdata_i;
      end
      line_q  <= line_d;
      cyc_q   <= cyc_d;
      vb_q    <= vb_d;
      hb_q    <= hb_d;
      res_v_q <= accept;
      rd_ok_q <= accept && (item_i.cmd == CMD_PIX_RD) && rd_in_frame;
    end
  end

  stbr_render #(
    .PIXELS_PER_LINE (PIXELS_PER_LINE),
    .VISIBLE_LINES   (VISIBLE_LINES),
    .TOTAL_LINES     (TOTAL_LINES),
    .VRAM_WORDS      (VRAM_WORDS)
  ) u_render (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (go),
    .kind_i       (go_kind),
    .frame_sel_i  (dctl_q[4]),
    .line_i       (line_q),
    .vram_rdata_i (vram_rdata),
    .pal_rdata_i  (pal_rdata),
    .req_o        (req),
    .busy_o       (rbusy)
  );

  stbr_ram #(.WIDTH(16), .DEPTH(VRAM_WORDS)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (item_i.vram_address[VAW-1:0]),
    .wdata_i (item_i.write_data),
    .re_i    (req.vram_re),
    .raddr_i (req.vram_addr[VAW-1:0]),
    .rdata_o (vram_rdata)
  );

  stbr_ram #(.WIDTH(16), .DEPTH(256)) u_palette (
    .clk_i   (clk_i),
    .we_i    (accept && (item_i.cmd == CMD_PAL_WR)),
    .waddr_i (item_i.palette_index),
    .wdata_i (item_i.write_data),
    .re_i    (req.pal_re),
    .raddr_i (req.pal_addr),
    .rdata_o (pal_rdata)
  );

  stbr_ram #(.WIDTH(16), .DEPTH(PIXELS_PER_LINE * VISIBLE_LINES)) u_frame (
    .clk_i   (clk_i),
    .we_i    (req.frame_we),
    .waddr_i (req.frame_addr[FAW-1:0]),
    .wdata_i (req.frame_wdata),
    .re_i    (accept && (item_i.cmd == CMD_PIX_RD) && rd_in_frame),
    .raddr_i (rd_addr_w[FAW-1:0]),
    .rdata_o (frame_rdata)
  );

  assign line_ext = 32'(line_q);
  assign cyc_ext  = 32'(cyc_q);

  always_comb begin
    result_o.line_number   = line_ext[7:0];
    result_o.cycle_in_line = cyc_ext[10:0];
    result_o.vblank_flag   = vb_q;
    result_o.hblank_flag   = hb_q;
    result_o.pixel_value   = rd_ok_q ? frame_rdata : 16'd0;
  end

  assign result_valid_o = res_v_q;

endmodule

// ===== src/stbr_checker.sv =====
// ----------------------------------------------------------------------------
// stbr_checker
// Port-level checks on the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "scanline_timing_bitmap_renderer_defines.svh"

module stbr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input stbr_pkg::item_t   item_i,
  input logic              result_valid_o,
  input stbr_pkg::result_t result_o
);
  import stbr_pkg::*;

  // every transfer gives exactly one result, in the next cycle
  `STBR_ASSERT_NEXT(a_result_follows, start && !busy, result_valid_o)
  `STBR_ASSERT_SAME(a_no_stray_result, result_valid_o, $past(start && !busy))
  // only pixel reads return pixel data
  `STBR_ASSERT_NEXT(a_pixel_zero, start && !busy && (item_i.cmd != CMD_PIX_RD), result_o.pixel_value == 16'd0)
  // a render only starts from a tick
  `STBR_ASSERT_SAME(a_busy_from_tick, $rose(busy), $past(start && (item_i.cmd == CMD_TICK)))

endmodule

bind scanline_timing_bitmap_renderer stbr_checker u_stbr_checker (.*);
